[rtl/srls_pkg.sv]
// Package for the sample-to-raster line sync block: widths, raster size,
// register indexes and reset values. No dependencies.
package srls_pkg;

	// Raster size
	localparam int LINE_WIDTH   = 800;
	localparam int FRAME_HEIGHT = 600;

	// Field widths
	localparam int SAMPLE_W  = 16;
	localparam int COORD_W   = 10;
	localparam int GRAY_W    = 8;
	localparam int LEVEL_W   = 12;
	localparam int SPACING_W = 16;
	localparam int MAX_W     = 16;
	localparam int MIN_W     = 17;

	// Normalization arithmetic
	localparam int DIFF_W    = MIN_W + 1;        // mag - previous_min, signed
	localparam int NUM_W     = DIFF_W + 8;       // diff * 255, signed
	localparam int QUO_W     = NUM_W - 1;        // magnitude of the numerator
	localparam int DEN_W     = MAX_W;            // positive span fits here
	localparam int DIV_STEPS = QUO_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int GRAY_OFFSET = 50;
	localparam int GRAY_MAX    = 255;

	// Configuration
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_THRESHOLD   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPACING_THRESHOLD = 2'd1;

	// Reset values
	localparam logic [LEVEL_W-1:0]   LEVEL_THRESHOLD_RST   = 12'd128;
	localparam logic [SPACING_W-1:0] SPACING_THRESHOLD_RST = 16'd128;
	localparam logic [MAX_W-1:0]     MAX_RST               = 16'd1;
	localparam logic [MIN_W-1:0]     MIN_RST               = 17'd1;
	localparam logic [MIN_W-1:0]     MIN_EMPTY             = 17'h1FFFF;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COORD_W-1:0]         coord_t;
	typedef logic [GRAY_W-1:0]          gray_t;
	typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
	typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

endpackage

[rtl/sample_to_raster_line_sync.sv]
// Top level of the sample-to-raster line sync block: magnitude, block range
// tracking, normalization by a restoring divider, sync and raster position.
// Depends on srls_pkg.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  sample   | sample_valid/sample_stall | sample_value, end_of_block
//  pixel    | pixel_valid/pixel_stall   | pixel_x, pixel_y, gray_level, line_sync
//  cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// The output register loads after the accepting edge passes through a scaling
// state, the iterations of the one-bit-per-cycle restoring divider, then a
// finish state that waits while the output register is still full and
// stalled. The next item is taken in the cycle after finish; sample_stall holds
// off new samples until the current one is through finish.
// arst_n clears all control and range state; cfg_ready is always high.
module sample_to_raster_line_sync (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  srls_pkg::sample_t     sample_value,
	input  logic                  end_of_block,
	output logic                  pixel_valid,
	input  logic                  pixel_stall,
	output srls_pkg::coord_t      pixel_x,
	output srls_pkg::coord_t      pixel_y,
	output srls_pkg::gray_t       gray_level,
	output logic                  line_sync,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  srls_pkg::cfg_index_t  cfg_index,
	input  srls_pkg::cfg_data_t   cfg_data
);
	import srls_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCALE = 2'd1;
	localparam logic [1:0] ST_DIV   = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]           state_q;
	logic [STEP_W-1:0]    step_q;
	logic [LEVEL_W-1:0]   level_thr_q;
	logic [SPACING_W-1:0] spacing_thr_q;
	logic [MAX_W-1:0]     run_max_q;
	logic [MIN_W-1:0]     run_min_q;
	logic [MAX_W-1:0]     prev_max_q;
	logic [MIN_W-1:0]     prev_min_q;
	logic [COORD_W-1:0]   col_q;
	logic [COORD_W-1:0]   row_q;
	logic [SPACING_W-1:0] spacing_q;
	logic                 pixel_valid_q;

	// Datapath registers (no reset)
	logic [MAX_W-1:0] mag_q;
	logic             last_q;
	logic             neg_q;
	logic             span_pos_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	coord_t           pixel_x_q;
	coord_t           pixel_y_q;
	gray_t            gray_q;
	logic             sync_q;

	logic                     accept;
	logic [MAX_W-1:0]         mag_in;
	logic signed [DIFF_W-1:0] diff;
	logic signed [NUM_W-1:0]  num;
	logic [NUM_W-1:0]         num_abs;
	logic [DIFF_W-1:0]        span;
	logic                     span_pos;
	logic [DEN_W:0]           trial_in;
	logic [DEN_W+1:0]         trial;
	logic                     trial_ge;
	logic signed [NUM_W-1:0]  norm;
	logic signed [NUM_W:0]    gray_sum;
	gray_t                    gray;
	logic                     sync;
	logic [COORD_W:0]         col_sum;
	logic [COORD_W:0]         row_sum;
	coord_t                   col_next;
	coord_t                   row_next;
	logic [SPACING_W-1:0]     spacing_next;
	logic                     out_free;
	logic                     finish;

	// Handshakes
	assign sample_stall = (state_q != ST_IDLE);
	assign accept       = sample_valid && !sample_stall;
	assign cfg_ready    = 1'b1;
	assign out_free     = !pixel_valid_q || !pixel_stall;
	assign finish       = (state_q == ST_DONE) && out_free;

	// Magnitude; the most negative sample maps to 0x8000
	assign mag_in = sample_value[SAMPLE_W-1] ? (MAX_W'(~sample_value) + MAX_W'(1))
	                                         : MAX_W'(sample_value);

	// Scale: signed numerator (mag - previous_min) * 255 and span
	always_comb begin
		diff     = signed'({2'b00, mag_q}) - signed'({1'b0, prev_min_q});
		num      = signed'({diff, 8'd0}) - signed'({{(NUM_W-DIFF_W){diff[DIFF_W-1]}}, diff});
		num_abs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
		span     = {2'b00, prev_max_q} - {1'b0, prev_min_q};
		span_pos = {1'b0, prev_max_q} > prev_min_q;
	end

	// Divider step: shift one numerator bit into the remainder, subtract if it fits
	always_comb begin
		trial_in = {rem_q, quo_q[QUO_W-1]};
		trial    = {1'b0, trial_in} - {2'b00, den_q};
		trial_ge = !trial[DEN_W+1];
	end

	// Finish: signed quotient, sync decision, gray clamp, raster counters
	always_comb begin
		norm = '0;
		if (span_pos_q) begin
			norm = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
		end
		sync = (norm > signed'({{(NUM_W-LEVEL_W){1'b0}}, level_thr_q}))
		       && (spacing_q > spacing_thr_q);

		gray_sum = signed'({norm[NUM_W-1], norm}) + signed'((NUM_W+1)'(GRAY_OFFSET));
		if (gray_sum < 0) begin
			gray = '0;
		end else if (gray_sum > signed'((NUM_W+1)'(GRAY_MAX))) begin
			gray = gray_t'(GRAY_MAX);
		end else begin
			gray = gray_sum[GRAY_W-1:0];
		end

		col_sum = sync ? '0 : ({1'b0, col_q} + (COORD_W+1)'(1));
		row_sum = sync ? ({1'b0, row_q} + (COORD_W+1)'(1)) : {1'b0, row_q};
		col_next = (col_sum >= (COORD_W+1)'(LINE_WIDTH)) ? '0 : col_sum[COORD_W-1:0];
		row_next = (row_sum >= (COORD_W+1)'(FRAME_HEIGHT)) ? '0 : row_sum[COORD_W-1:0];

		if (sync) begin
			spacing_next = '0;
		end else if (spacing_q == '1) begin
			spacing_next = spacing_q;
		end else begin
			spacing_next = spacing_q + SPACING_W'(1);
		end
	end

	// Sequencer, configuration and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			level_thr_q   <= LEVEL_THRESHOLD_RST;
			spacing_thr_q <= SPACING_THRESHOLD_RST;
			run_max_q     <= MAX_RST;
			run_min_q     <= MIN_EMPTY;
			prev_max_q    <= MAX_RST;
			prev_min_q    <= MIN_RST;
			col_q         <= '0;
			row_q         <= '0;
			spacing_q     <= '0;
			pixel_valid_q <= 1'b0;
		end else begin
			// Write configuration registers; ignore unknown indexes
			if (cfg_valid) begin
				case (cfg_index)
					REG_LEVEL_THRESHOLD:   level_thr_q   <= cfg_data[LEVEL_W-1:0];
					REG_SPACING_THRESHOLD: spacing_thr_q <= cfg_data[SPACING_W-1:0];
					default: ;
				endcase
			end

			// Load the output item on finish, drop it once taken
			if (finish) begin
				pixel_valid_q <= 1'b1;
			end else if (!pixel_stall) begin
				pixel_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mag_in > run_max_q) begin
							run_max_q <= mag_in;
						end
						if ({1'b0, mag_in} < run_min_q) begin
							run_min_q <= {1'b0, mag_in};
						end
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						spacing_q <= spacing_next;
						if (last_q) begin
							prev_max_q <= run_max_q;
							prev_min_q <= run_min_q;
							run_max_q  <= MAX_RST;
							run_min_q  <= MIN_EMPTY;
							col_q      <= '0;
							row_q      <= '0;
						end else begin
							col_q <= col_next;
							row_q <= row_next;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: capture, scale, divide, load output
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag_in;
			last_q <= end_of_block;
		end
		if (state_q == ST_SCALE) begin
			neg_q      <= num[NUM_W-1];
			span_pos_q <= span_pos;
			den_q      <= span[DEN_W-1:0];
			rem_q      <= '0;
			quo_q      <= num_abs[QUO_W-1:0];
		end
		if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? trial[DEN_W-1:0] : trial_in[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], trial_ge};
		end
		if (finish) begin
			pixel_x_q <= col_next;
			pixel_y_q <= row_next;
			gray_q    <= gray;
			sync_q    <= sync;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign gray_level  = gray_q;
	assign line_sync   = sync_q;

endmodule

[bench/srls_checker.sv]
`timescale 1ns / 100ps
// Checker for the sample-to-raster line sync block: watches the sample, pixel
// and register channels, predicts every pixel item and compares it field by field.
// Depends on srls_pkg.
module srls_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  srls_pkg::sample_t    sample_value,
	input  logic                 end_of_block,
	input  logic                 pixel_valid,
	input  logic                 pixel_stall,
	input  srls_pkg::coord_t     pixel_x,
	input  srls_pkg::coord_t     pixel_y,
	input  srls_pkg::gray_t      gray_level,
	input  logic                 line_sync,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  srls_pkg::cfg_index_t cfg_index,
	input  srls_pkg::cfg_data_t  cfg_data,
	output int                   mismatches,
	output int                   pending_results,
	output int                   pixels_checked,
	output int                   syncs_seen
);
	import srls_pkg::*;

	typedef struct packed {
		coord_t x;
		coord_t y;
		gray_t  gray;
		logic   sync;
	} pixel_t;

	// Shadow copy of the block's registers and range/raster state
	logic [LEVEL_W-1:0]   level_thr;
	logic [SPACING_W-1:0] spacing_thr;
	logic [MAX_W-1:0]     cur_max;
	logic [MIN_W-1:0]     cur_min;
	logic [MAX_W-1:0]     last_max;
	logic [MIN_W-1:0]     last_min;
	coord_t               column;
	coord_t               row;
	logic [SPACING_W-1:0] since_sync;

	pixel_t expected_pixels[$];

	// Place one sample on the raster and advance the shadow state
	task automatic place_sample(input sample_t value, input logic last, output pixel_t px);
		logic [MIN_W-1:0] mag;
		longint           num;
		longint           span;
		longint           norm;
		longint           gray_wide;
		logic             fire;
		mag = value[SAMPLE_W-1] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
		if (mag > cur_max)
			cur_max = mag[MAX_W-1:0];
		if (mag < cur_min)
			cur_min = mag;

		// Normalize against the previous block; zero when the span is not positive
		norm = 0;
		if (last_max > last_min) begin
			num  = (longint'(mag) - longint'(last_min)) * 255;
			span = longint'(last_max) - longint'(last_min);
			norm = num / span;
		end

		fire = (norm > longint'(level_thr)) && (since_sync > spacing_thr);
		if (fire) begin
			column     = '0;
			row        = row + 1'b1;
			since_sync = '0;
		end else begin
			column = column + 1'b1;
			if (since_sync != '1)
				since_sync = since_sync + 1'b1;
		end
		if (column >= LINE_WIDTH)
			column = '0;
		if (row >= FRAME_HEIGHT)
			row = '0;

		gray_wide = norm + GRAY_OFFSET;
		if (gray_wide > GRAY_MAX)
			gray_wide = GRAY_MAX;
		if (gray_wide < 0)
			gray_wide = 0;

		px.x    = column;
		px.y    = row;
		px.gray = gray_t'(gray_wide);
		px.sync = fire;

		// Roll the block range over and restart the raster
		if (last) begin
			last_max = cur_max;
			last_min = cur_min;
			cur_max  = MAX_RST;
			cur_min  = MIN_EMPTY;
			column   = '0;
			row      = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_t want;
		pixel_t got;
		if (!arst_n) begin
			level_thr       = LEVEL_THRESHOLD_RST;
			spacing_thr     = SPACING_THRESHOLD_RST;
			cur_max         = MAX_RST;
			cur_min         = MIN_EMPTY;
			last_max        = MAX_RST;
			last_min        = MIN_RST;
			column          = '0;
			row             = '0;
			since_sync      = '0;
			mismatches      = 0;
			pending_results = 0;
			pixels_checked  = 0;
			syncs_seen      = 0;
			expected_pixels.delete();
		end else begin
			// Register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LEVEL_THRESHOLD)
					level_thr = cfg_data[LEVEL_W-1:0];
				else if (cfg_index == REG_SPACING_THRESHOLD)
					spacing_thr = cfg_data[SPACING_W-1:0];
			end

			// Check the pixel item against the oldest prediction
			if (pixel_valid && !pixel_stall) begin
				got = '{pixel_x, pixel_y, gray_level, line_sync};
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("srls_checker: unexpected pixel x=%0d y=%0d gray=%0d sync=%0b",
							got.x, got.y, got.gray, got.sync);
				end else begin
					want = expected_pixels.pop_front();
					pixels_checked++;
					if (got.sync === 1'b1)
						syncs_seen++;
					if (want.x !== got.x || want.y !== got.y || want.gray !== got.gray ||
							want.sync !== got.sync) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"srls_checker: pixel mismatch, expected x=%0d y=%0d ",
								"gray=%0d sync=%0b, got x=%0d y=%0d gray=%0d sync=%0b"},
								want.x, want.y, want.gray, want.sync,
								got.x, got.y, got.gray, got.sync);
					end
				end
			end

			// Predict the pixel for each accepted sample
			if (sample_valid && !sample_stall) begin
				place_sample(sample_value, end_of_block, want);
				expected_pixels.push_back(want);
			end
			pending_results = expected_pixels.size();
		end
	end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// Testbench top for the sample-to-raster line sync block: drives samples, register
// writes and pixel back-pressure, and gives the verdict. Depends on srls_pkg and srls_checker.
module tb;
	import srls_pkg::*;

	localparam int         CYCLE_LIMIT  = 600000;
	localparam int         LONG_HOLD    = 400;
	localparam int         LONG_BLOCK   = 805;
	localparam int         PHASES       = 6;
	localparam int         PHASE_ITEMS  = 25;
	localparam cfg_index_t REG_SPARE_A  = 2'd2;
	localparam cfg_index_t REG_SPARE_B  = 2'd3;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       sample_valid;
	logic       sample_stall;
	sample_t    sample_value;
	logic       end_of_block;
	logic       pixel_valid;
	logic       pixel_stall;
	coord_t     pixel_x;
	coord_t     pixel_y;
	gray_t      gray_level;
	logic       line_sync;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_index_t cfg_index;
	cfg_data_t  cfg_data;

	int mismatches;
	int pending_results;
	int pixels_checked;
	int syncs_seen;

	int cycle_count   = 0;
	int samples_sent  = 0;
	int reg_writes    = 0;
	int hold_off_left = 0;
	bit calm          = 1'b1;

	sample_to_raster_line_sync u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.end_of_block (end_of_block),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.gray_level   (gray_level),
		.line_sync    (line_sync),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	srls_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample_value    (sample_value),
		.end_of_block    (end_of_block),
		.pixel_valid     (pixel_valid),
		.pixel_stall     (pixel_stall),
		.pixel_x         (pixel_x),
		.pixel_y         (pixel_y),
		.gray_level      (gray_level),
		.line_sync       (line_sync),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.pending_results (pending_results),
		.pixels_checked  (pixels_checked),
		.syncs_seen      (syncs_seen)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Mostly magnitudes near a center so norms land around 0..255, plus noise and extremes
	function automatic sample_t pick_sample(input int center);
		int r;
		int m;
		r = $urandom_range(0, 9);
		if (r < 7) begin
			m = center + $urandom_range(0, 40);
			return $urandom_range(0, 1) ? sample_t'(-m) : sample_t'(m);
		end else if (r < 9) begin
			return sample_t'($urandom_range(0, 65535));
		end
		case ($urandom_range(0, 4))
			0: return sample_t'(16'h8000);
			1: return sample_t'(16'h7FFF);
			2: return sample_t'(0);
			3: return sample_t'(1);
			default: return sample_t'(-1);
		endcase
	endfunction

	function automatic int pick_center();
		return $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 32000);
	endfunction

	// Offer one sample item and hold it until accepted
	task automatic push_sample(input sample_t value, input logic last);
		int idle;
		idle = calm ? 0 : gap_len();
		if (idle > 0) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample_value <= value;
		end_of_block <= last;
		do @(posedge clk); while (sample_stall);
		samples_sent++;
	endtask

	task automatic write_register(input cfg_index_t idx, input cfg_data_t data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Stop offering samples and wait for every predicted pixel
	task automatic drain_pixels();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	// Short blocks with random content under one register setting
	task automatic run_phase(input int count, input bit pause_midway);
		int center;
		center = pick_center();
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0)
				center = pick_center();
			push_sample(pick_sample(center), $urandom_range(0, 5) == 0);
			if (pause_midway && i == count / 2)
				drain_pixels();
		end
		drain_pixels();
	endtask

	// Pixel back-pressure, with a long hold-off on request
	initial begin
		int stall_left;
		stall_left  = 0;
		pixel_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				pixel_stall <= 1'b1;
				hold_off_left--;
			end else if (stall_left > 0) begin
				pixel_stall <= 1'b1;
				stall_left--;
			end else begin
				pixel_stall <= 1'b0;
				if (!calm)
					stall_left = gap_len();
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Stimulus
	initial begin
		int        center;
		cfg_data_t level_word;
		cfg_data_t spacing_word;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample_value = '0;
		end_of_block = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_LEVEL_THRESHOLD;
		cfg_data     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero span after reset, extremes, single-sample blocks, then a two-sample block
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(16'h7FFF), 1'b0);
		push_sample(sample_t'(16'h8000), 1'b0);
		push_sample(sample_t'(-1), 1'b1);
		push_sample(sample_t'(5), 1'b1);
		push_sample(sample_t'(1234), 1'b1);
		push_sample(sample_t'(1000), 1'b0);
		push_sample(sample_t'(1010), 1'b1);
		// Below the range clamps gray low, above it clamps high
		push_sample(sample_t'(0), 1'b0);
		push_sample(sample_t'(1010), 1'b0);
		push_sample(sample_t'(2000), 1'b0);
		drain_pixels();

		// Lowest thresholds; upper data bits must be masked, spare indexes dropped
		write_register(REG_LEVEL_THRESHOLD, 16'hF000);
		write_register(REG_SPACING_THRESHOLD, 16'h0000);
		write_register(REG_SPARE_A, 16'hFFFF);
		write_register(REG_SPARE_B, 16'hFFFF);
		push_sample(sample_t'(1005), 1'b0);
		push_sample(sample_t'(1006), 1'b0);
		push_sample(sample_t'(1007), 1'b0);
		push_sample(sample_t'(1000), 1'b0);
		drain_pixels();

		// Highest thresholds: a large norm alone must not sync
		write_register(REG_LEVEL_THRESHOLD, 16'hFFFF);
		write_register(REG_SPACING_THRESHOLD, 16'hFFFF);
		push_sample(sample_t'(30000), 1'b0);
		drain_pixels();

		// Norm above the top level threshold with no spacing requirement
		write_register(REG_SPACING_THRESHOLD, 16'h0000);
		push_sample(sample_t'(30000), 1'b0);
		push_sample(sample_t'(-30000), 1'b0);
		push_sample(sample_t'(30000), 1'b0);
		push_sample(sample_t'(16'h8000), 1'b1);
		drain_pixels();

		// One long block without syncs so the column wraps; hold off pixels early on
		write_register(REG_SPACING_THRESHOLD, 16'hFFFF);
		calm   = 1'b0;
		center = pick_center();
		for (int i = 0; i < LONG_BLOCK; i++) begin
			if (i == 100)
				hold_off_left = LONG_HOLD;
			if ($urandom_range(0, 31) == 0)
				center = pick_center();
			push_sample(pick_sample(center), i == LONG_BLOCK - 1);
		end
		drain_pixels();

		// Random settings with short blocks; every third phase runs without gaps
		for (int p = 0; p < PHASES; p++) begin
			case ($urandom_range(0, 5))
				0: level_word = cfg_data_t'($urandom_range(0, 15) << LEVEL_W);
				1: level_word = {4'($urandom_range(0, 15)), 12'hFFF};
				default: level_word = cfg_data_t'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 7))
				0: spacing_word = 16'h0000;
				1: spacing_word = 16'hFFFF;
				default: spacing_word = cfg_data_t'($urandom_range(0, 6));
			endcase
			write_register(REG_LEVEL_THRESHOLD, level_word);
			write_register(REG_SPACING_THRESHOLD, spacing_word);
			calm = (p % 3 == 2);
			run_phase(PHASE_ITEMS, p == 0);
		end

		calm = 1'b1;
		drain_pixels();
		repeat (40) @(posedge clk);

		$display("tb: %0d samples sent, %0d pixels checked, %0d line syncs, %0d register writes",
			samples_sent, pixels_checked, syncs_seen, reg_writes);
		$display("tb: covered zero span, gray clamps, threshold extremes and a column wrap");
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
